@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sample front end.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define SSDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define SSDC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SSDC_ASSERT(lbl, prop, msg)
`define SSDC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/ssdc_pkg.sv @@
// Shared types, constants and the level-table lookup of the sample front end.
// No dependencies.
package ssdc_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MAG_W     = 15;
  localparam int unsigned BIN_W     = 10;
  localparam int unsigned CODE_W    = 9;
  localparam int unsigned DIFF_W    = 10;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned HIST_BINS = 1 << BIN_W;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 120;

  // Item kinds carried in tuser
  localparam logic KIND_SAMPLE   = 1'b0;
  localparam logic KIND_BIN_READ = 1'b1;

  // level(i) = 31 + 64*i + floor((64*i + 511) / 1022)
  localparam logic [MAG_W-1:0]  LEVEL_BASE = 15'd31;
  localparam logic [15:0]       ROUND_BIAS = 16'd511;
  localparam logic [15:0]       ROUND_DIV  = 16'd1022;
  localparam logic [DIFF_W-1:0] DIFF_ZERO  = 10'd511;

  typedef struct packed {
    logic hit;
    logic [CODE_W-1:0] code;
  } level_match_t;

  // Item after the sample stage, on its way to the histogram stage
  typedef struct packed {
    logic               kind;
    logic               sign_flip;
    logic [CODE_W-1:0]  level_code;
    logic               matched;
    logic [DIFF_W-1:0]  diff_code;
    logic               diff_valid;
    logic [BIN_W-1:0]   hist_addr;
    logic [TOTAL_W-1:0] change_total;
    logic [TOTAL_W-1:0] sample_total;
  } item_t;

  // Finished result
  typedef struct packed {
    logic               sign_flip;
    logic [CODE_W-1:0]  level_code;
    logic               matched;
    logic [DIFF_W-1:0]  diff_code;
    logic               diff_valid;
    logic [TOTAL_W-1:0] bin_count;
    logic [TOTAL_W-1:0] change_total;
    logic [TOTAL_W-1:0] sample_total;
  } result_t;

  // Reverse lookup in the level table. Since the rounding term stays below 64,
  // the candidate index is the offset magnitude over 64 and the low six bits
  // must equal the rounding term of that index.
  function automatic level_match_t level_lookup(input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0]  ofs;
    logic [CODE_W-1:0] idx;
    logic [5:0]        frac;
    logic [15:0]       num;
    logic [5:0]        q0;
    logic [15:0]       rem;
    logic [5:0]        rnd;
    level_match_t      res;
    ofs  = mag - LEVEL_BASE;
    idx  = ofs[14:6];
    frac = ofs[5:0];
    num  = {1'b0, idx, 6'b0} + ROUND_BIAS;
    // num / 1024 is the quotient or one short of it
    q0   = num[15:10];
    rem  = num - 16'(q0 * ROUND_DIV);
    rnd  = (rem >= ROUND_DIV) ? q0 + 6'd1 : q0;
    res.hit  = (mag >= LEVEL_BASE) && (rnd == frac);
    res.code = res.hit ? idx : '0;
    return res;
  endfunction

endpackage

@@ rtl/ssdc_sample_stage.sv @@
// Input register, sign tracking, level lookup, code difference and totals.
// Depends on ssdc_pkg.
module ssdc_sample_stage import ssdc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enable_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_kind_i,
  input  logic [SAMPLE_W-1:0] in_raw_i,
  input  logic [BIN_W-1:0]    in_bin_i,
  output logic                item_valid_o,
  output item_t               item_o,
  input  logic                item_ready_i
);

  logic                   s1_valid_q;
  logic                   s1_kind_q;
  logic [SAMPLE_W-1:0]    s1_raw_q;
  logic [BIN_W-1:0]       s1_bin_q;

  logic                   last_pos_q, last_pos_d;
  logic [CODE_W-1:0]      prev_code_q;
  logic                   have_prev_q;
  logic [COUNT_WIDTH-1:0] change_cnt_q, change_cnt_d;
  logic [COUNT_WIDTH-1:0] sample_cnt_q, sample_cnt_d;

  logic                   in_fire, s1_fire;
  logic                   is_sample, is_neg, is_pos, sign_flip;
  logic [MAG_W-1:0]       mag;
  level_match_t           match;
  logic [CODE_W-1:0]      code;
  logic [DIFF_W-1:0]      diff;
  logic                   diff_valid;

  assign in_ready_o   = enable_i && (!s1_valid_q || item_ready_i);
  assign in_fire      = in_valid_i && in_ready_o;
  assign s1_fire      = s1_valid_q && item_ready_i;
  assign item_valid_o = s1_valid_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_kind_i;
      s1_raw_q  <= in_raw_i;
      s1_bin_q  <= in_bin_i;
    end
  end

  // Sign tracking; zero counts as neither sign
  assign is_sample = (s1_kind_q == KIND_SAMPLE);
  assign is_neg    = !s1_raw_q[SAMPLE_W-1];
  assign is_pos    = s1_raw_q[SAMPLE_W-1] && (|s1_raw_q[MAG_W-1:0]);
  assign sign_flip = is_sample && ((is_neg && last_pos_q) || (is_pos && !last_pos_q));

  always_comb begin
    last_pos_d = last_pos_q;
    if (is_sample && is_neg) begin
      last_pos_d = 1'b0;
    end else if (is_sample && is_pos) begin
      last_pos_d = 1'b1;
    end
  end

  // Fold to magnitude: 32767 - raw below mid, raw - 32768 otherwise
  assign mag   = s1_raw_q[SAMPLE_W-1] ? s1_raw_q[MAG_W-1:0] : ~s1_raw_q[MAG_W-1:0];
  assign match = level_lookup(mag);
  assign code  = is_sample ? match.code : '0;

  // Code difference, offset so it stays non-negative
  assign diff       = DIFF_W'(code) + DIFF_ZERO - DIFF_W'(prev_code_q);
  assign diff_valid = is_sample && have_prev_q;

  // Saturating totals
  assign change_cnt_d = (sign_flip && (change_cnt_q != '1)) ?
                        change_cnt_q + COUNT_WIDTH'(1) : change_cnt_q;
  assign sample_cnt_d = (is_sample && (sample_cnt_q != '1)) ?
                        sample_cnt_q + COUNT_WIDTH'(1) : sample_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q   <= 1'b1;
      prev_code_q  <= '0;
      have_prev_q  <= 1'b0;
      change_cnt_q <= '0;
      sample_cnt_q <= '0;
    end else if (s1_fire) begin
      last_pos_q   <= last_pos_d;
      change_cnt_q <= change_cnt_d;
      sample_cnt_q <= sample_cnt_d;
      if (is_sample) begin
        prev_code_q <= code;
        have_prev_q <= 1'b1;
      end
    end
  end

  // Item toward the histogram stage
  always_comb begin
    item_o.kind         = s1_kind_q;
    item_o.sign_flip    = sign_flip;
    item_o.level_code   = code;
    item_o.matched      = is_sample && match.hit;
    item_o.diff_code    = diff_valid ? diff : '0;
    item_o.diff_valid   = diff_valid;
    item_o.hist_addr    = is_sample ? diff : s1_bin_q;
    item_o.change_total = TOTAL_W'(change_cnt_d);
    item_o.sample_total = TOTAL_W'(sample_cnt_d);
  end

endmodule

@@ rtl/ssdc_hist.sv @@
// Difference histogram: bin memory, clearing pass after reset and
// read-modify-write stage with write forwarding. Depends on ssdc_pkg.
module ssdc_hist import ssdc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  output logic    clear_done_o,
  input  logic    item_valid_i,
  output logic    item_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  logic [COUNT_WIDTH-1:0] hist_mem [HIST_BINS];

  logic [BIN_W:0]         clr_cnt_q;
  logic                   clearing;

  logic                   s2_valid_q;
  item_t                  s2_item_q;
  logic [COUNT_WIDTH-1:0] rd_q;

  logic                   lw_valid_q;
  logic [BIN_W-1:0]       lw_addr_q;
  logic [COUNT_WIDTH-1:0] lw_data_q;

  logic                   item_fire, s2_fire, item_wr;
  logic [COUNT_WIDTH-1:0] fwd, bumped;
  logic                   wr_en;
  logic [BIN_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  assign clearing     = !clr_cnt_q[BIN_W];
  assign clear_done_o = clr_cnt_q[BIN_W];

  assign item_ready_o = !s2_valid_q || res_ready_i;
  assign item_fire    = item_valid_i && item_ready_o;
  assign s2_fire      = s2_valid_q && res_ready_i;
  assign res_valid_o  = s2_valid_q;

  // Clearing pass, one bin per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + (BIN_W+1)'(1);
    end
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (item_fire) begin
      s2_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      s2_item_q <= item_i;
    end
  end

  // Bin read, registered
  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      rd_q <= hist_mem[item_i.hist_addr];
    end
  end

  // A write at the read edge is not yet in rd_q: take the latest write instead
  assign fwd    = (lw_valid_q && (lw_addr_q == s2_item_q.hist_addr)) ? lw_data_q : rd_q;
  assign bumped = (fwd != '1) ? fwd + COUNT_WIDTH'(1) : fwd;

  assign item_wr = s2_fire && (s2_item_q.kind == KIND_SAMPLE) && s2_item_q.diff_valid;

  // Write port shared by clearing and bin updates
  assign wr_en   = clearing || item_wr;
  assign wr_addr = clearing ? clr_cnt_q[BIN_W-1:0] : s2_item_q.hist_addr;
  assign wr_data = clearing ? '0 : bumped;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
  end

  // Latest bin update, for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (item_wr) begin
      lw_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_wr) begin
      lw_addr_q <= s2_item_q.hist_addr;
      lw_data_q <= bumped;
    end
  end

  // Result
  always_comb begin
    res_o.sign_flip    = s2_item_q.sign_flip;
    res_o.level_code   = s2_item_q.level_code;
    res_o.matched      = s2_item_q.matched;
    res_o.diff_code    = s2_item_q.diff_code;
    res_o.diff_valid   = s2_item_q.diff_valid;
    res_o.bin_count    = (s2_item_q.kind == KIND_BIN_READ) ? TOTAL_W'(fwd) : '0;
    res_o.change_total = s2_item_q.change_total;
    res_o.sample_total = s2_item_q.sample_total;
  end

endmodule

@@ rtl/sample_sign_delta_code_front_end.sv @@
// Sample front end: flags sign changes, maps each sample magnitude to its level
// code, and counts code differences in a 1024-bin histogram whose bins can be
// read back with a bin-read item. One item is taken per clock cycle unless the
// output or clearing stalls it; an output register holds each result under
// backpressure. The histogram sits in a single-write, single-read memory and each
// sample with a code difference updates it by a read-modify-write across two
// pipeline stages, with the latest write forwarded so back-to-back hits on one
// bin count right. After reset a clearing pass zeroes all 1024 bins, during which
// s_axis_tready stays low. Counters saturate at 2^COUNT_WIDTH - 1. Depends on
// ssdc_pkg, ssdc_sample_stage, ssdc_hist and assert_macros.svh.
`include "assert_macros.svh"

module sample_sign_delta_code_front_end import ssdc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] raw_sample, [25:16] bin_index, [31:26] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic [0:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] sign_flip, [9:1] level_code, [10] matched, [20:11] diff_code,
  // [21] diff_valid, [53:22] bin_count, [85:54] change_total,
  // [117:86] sample_total, [119:118] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    clear_done;
  logic    item_valid, item_ready;
  item_t   item;
  logic    res_valid, res_ready;
  result_t res;

  logic    out_valid_q;
  result_t out_q;

  // Sample stage
  ssdc_sample_stage #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sample_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (clear_done),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser[0]),
    .in_raw_i     (s_axis_tdata[SAMPLE_W-1:0]),
    .in_bin_i     (s_axis_tdata[SAMPLE_W+BIN_W-1:SAMPLE_W]),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  // Histogram stage
  ssdc_hist #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_done_o (clear_done),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.sample_total, out_q.change_total, out_q.bin_count,
                          out_q.diff_valid, out_q.diff_code, out_q.matched,
                          out_q.level_code, out_q.sign_flip};

  // Checks
  `SSDC_ASSERT(a_clear_stays_done, clear_done |=> clear_done, "clearing pass restarted")
  `SSDC_ASSERT_NEVER(a_no_transfer_in_clear, s_axis_tvalid && s_axis_tready && !clear_done, "input transfer during clearing pass")
  `SSDC_ASSERT(a_bin_read_clean, (out_valid_q && (out_q.bin_count != '0)) |-> (!out_q.diff_valid && !out_q.sign_flip && !out_q.matched), "bin count on a sample result")
  `SSDC_ASSERT(a_unmatched_code_zero, (out_valid_q && !out_q.matched) |-> (out_q.level_code == '0), "level code without match")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sample front end: a directed table and random
// traffic under four handshake pressure phases.
// Depends on ssdc_pkg and the top module sample_sign_delta_code_front_end.

module tb;
  import ssdc_pkg::*;

  // Counter width of the device under test
  localparam int unsigned COUNT_W = 16;
  localparam logic [TOTAL_W-1:0] COUNT_MAX = TOTAL_W'((64'd1 << COUNT_W) - 1);

  // Level table: level(i) = BASE + (i * 2 * SPAN + (N - 1)) / (2 * (N - 1))
  localparam int unsigned LEVEL_COUNT = 512;
  localparam int unsigned LEVEL_FLOOR = 31;
  localparam int unsigned LEVEL_SPAN  = 32736;
  localparam int unsigned MID_CODE    = 32768;
  localparam int unsigned DIFF_BIAS   = 511;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 250;

  typedef struct packed {
    logic               sign_flip;
    logic [CODE_W-1:0]  level_code;
    logic               matched;
    logic [DIFF_W-1:0]  diff_code;
    logic               diff_valid;
    logic [TOTAL_W-1:0] bin_count;
    logic [TOTAL_W-1:0] change_total;
    logic [TOTAL_W-1:0] sample_total;
  } front_end_result_t;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] raw;
    logic [BIN_W-1:0]    bin;
    logic                typed;
    front_end_result_t   res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state
  logic               last_positive;
  logic [CODE_W-1:0]  prev_code;
  logic               have_prev;
  logic [TOTAL_W-1:0] diff_hist [HIST_BINS];
  logic [TOTAL_W-1:0] change_cnt;
  logic [TOTAL_W-1:0] sample_cnt;
  // Magnitude to {hit, code}
  logic [CODE_W:0]    code_of_mag [1 << MAG_W];

  front_end_result_t expected_results [$];
  stim_row_t         directed_rows [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;

  sample_sign_delta_code_front_end #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned level_value(input int unsigned idx);
    return LEVEL_FLOOR + (idx * 2 * LEVEL_SPAN + (LEVEL_COUNT - 1)) / (2 * (LEVEL_COUNT - 1));
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_step(input logic [TOTAL_W-1:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
  endfunction

  function automatic front_end_result_t mk_res(
      input logic sc, input logic [CODE_W-1:0] code, input logic hit,
      input logic [DIFF_W-1:0] dcode, input logic dvalid,
      input logic [TOTAL_W-1:0] bcount, input logic [TOTAL_W-1:0] ctotal,
      input logic [TOTAL_W-1:0] stotal);
    front_end_result_t r;
    r.sign_flip    = sc;
    r.level_code   = code;
    r.matched      = hit;
    r.diff_code    = dcode;
    r.diff_valid   = dvalid;
    r.bin_count    = bcount;
    r.change_total = ctotal;
    r.sample_total = stotal;
    return r;
  endfunction

  // Expected result of one item; advances the predictor state on samples
  function automatic front_end_result_t predict_front_end(
      input logic kind, input logic [SAMPLE_W-1:0] raw, input logic [BIN_W-1:0] bin);
    front_end_result_t r;
    logic [MAG_W-1:0]  mag;
    logic [CODE_W:0]   look;
    r = '0;
    if (kind == KIND_BIN_READ) begin
      r.bin_count = diff_hist[bin];
    end else begin
      if (raw < MID_CODE && last_positive) begin
        r.sign_flip = 1'b1;
        last_positive = 1'b0;
      end else if (raw > MID_CODE && !last_positive) begin
        r.sign_flip = 1'b1;
        last_positive = 1'b1;
      end
      if (r.sign_flip) change_cnt = sat_step(change_cnt);
      mag = (raw < MID_CODE) ? MAG_W'(MID_CODE - 1 - raw) : MAG_W'(raw - MID_CODE);
      look = code_of_mag[mag];
      r.matched    = look[CODE_W];
      r.level_code = look[CODE_W-1:0];
      if (have_prev) begin
        r.diff_code  = DIFF_W'(int'(r.level_code) + DIFF_BIAS - int'(prev_code));
        r.diff_valid = 1'b1;
        diff_hist[r.diff_code] = sat_step(diff_hist[r.diff_code]);
      end
      prev_code  = r.level_code;
      have_prev  = 1'b1;
      sample_cnt = sat_step(sample_cnt);
    end
    r.change_total = change_cnt;
    r.sample_total = sample_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
                             input logic [TOTAL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, name, got, want));
  endtask

  task automatic add_row(input logic kind, input logic [SAMPLE_W-1:0] raw,
                         input logic [BIN_W-1:0] bin, input logic typed,
                         input front_end_result_t res);
    stim_row_t row;
    row.kind  = kind;
    row.raw   = raw;
    row.bin   = bin;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  // Drive one item, wait for its transfer and queue what it should produce
  task automatic push_item(input logic kind, input logic [SAMPLE_W-1:0] raw,
                           input logic [BIN_W-1:0] bin, input logic typed,
                           input front_end_result_t typed_res);
    front_end_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, bin, raw};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_front_end(kind, raw, bin);
    expected_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Random sample, biased toward exact levels and the region around zero
  function automatic logic [SAMPLE_W-1:0] random_sample();
    int unsigned sel;
    int unsigned mag;
    logic [SAMPLE_W-1:0] raw;
    sel = $urandom_range(99);
    mag = level_value($urandom_range(LEVEL_COUNT - 1));
    if (sel < 40) begin
      raw = $urandom_range(1) ? SAMPLE_W'(MID_CODE + mag) : SAMPLE_W'(MID_CODE - 1 - mag);
    end else if (sel < 55) begin
      mag = $urandom_range(1) ? mag + 1 : mag - 1;
      mag = mag & 32'h7FFF;
      raw = $urandom_range(1) ? SAMPLE_W'(MID_CODE + mag) : SAMPLE_W'(MID_CODE - 1 - mag);
    end else if (sel < 65) begin
      raw = SAMPLE_W'(MID_CODE - 2 + $urandom_range(3));
    end else begin
      raw = SAMPLE_W'($urandom);
    end
    return raw;
  endfunction

  // Receiver backpressure
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Result checker
  always @(posedge clk_i) begin
    front_end_result_t got;
    front_end_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = mk_res(m_axis_tdata[0], m_axis_tdata[9:1], m_axis_tdata[10],
                   m_axis_tdata[20:11], m_axis_tdata[21], m_axis_tdata[53:22],
                   m_axis_tdata[85:54], m_axis_tdata[117:86]);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %0h", m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        check_field("sign_flip", got.sign_flip, want.sign_flip);
        check_field("level_code", got.level_code, want.level_code);
        check_field("matched", got.matched, want.matched);
        check_field("diff_code", got.diff_code, want.diff_code);
        check_field("diff_valid", got.diff_valid, want.diff_valid);
        check_field("bin_count", got.bin_count, want.bin_count);
        check_field("change_total", got.change_total, want.change_total);
        check_field("sample_total", got.sample_total, want.sample_total);
      end
      results_seen++;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned       ph;
    int unsigned       n;
    logic              kind;
    logic [BIN_W-1:0]  bin;
    stim_row_t         row;

    // Predictor reset and level map
    last_positive = 1'b1;
    prev_code     = '0;
    have_prev     = 1'b0;
    change_cnt    = '0;
    sample_cnt    = '0;
    for (n = 0; n < HIST_BINS; n++) diff_hist[n] = '0;
    for (n = 0; n < (1 << MAG_W); n++) code_of_mag[n] = '0;
    for (n = 0; n < LEVEL_COUNT; n++) code_of_mag[level_value(n)] = {1'b1, CODE_W'(n)};

    // Directed table; typed rows follow the sequence from reset
    add_row(KIND_BIN_READ, 16'hFFFF, 10'd0,   1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(KIND_BIN_READ, 16'h0000, 10'd1023, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
    // zero sample: no sign, no level, no difference yet
    add_row(KIND_SAMPLE, 16'd32768, 10'h3FF, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 1));
    add_row(KIND_SAMPLE, 16'd32799, 10'd0,   1'b1, mk_res(0, 0, 1, 511, 1, 0, 0, 2));
    add_row(KIND_SAMPLE, 16'd32736, 10'h3FF, 1'b1, mk_res(1, 0, 1, 511, 1, 0, 1, 3));
    // full-scale extremes
    add_row(KIND_SAMPLE, 16'd0,     10'd0,   1'b1, mk_res(0, 511, 1, 1022, 1, 0, 1, 4));
    add_row(KIND_SAMPLE, 16'd65535, 10'h155, 1'b1, mk_res(1, 511, 1, 511, 1, 0, 2, 5));
    // no match, difference down to zero
    add_row(KIND_SAMPLE, 16'd32768, 10'd0,   1'b1, mk_res(0, 0, 0, 0, 1, 0, 2, 6));
    add_row(KIND_SAMPLE, 16'd32767, 10'd0,   1'b1, mk_res(1, 0, 0, 511, 1, 0, 3, 7));
    add_row(KIND_SAMPLE, 16'd32769, 10'd0,   1'b1, mk_res(1, 0, 0, 511, 1, 0, 4, 8));
    // zero keeps the last sign
    add_row(KIND_SAMPLE, 16'd32768, 10'd0,   1'b1, mk_res(0, 0, 0, 511, 1, 0, 4, 9));
    add_row(KIND_BIN_READ, 16'hAAAA, 10'd511,  1'b1, mk_res(0, 0, 0, 0, 0, 6, 4, 9));
    add_row(KIND_BIN_READ, 16'h5555, 10'd1022, 1'b1, mk_res(0, 0, 0, 0, 0, 1, 4, 9));
    add_row(KIND_BIN_READ, 16'hFFFF, 10'd0,    1'b1, mk_res(0, 0, 0, 0, 0, 1, 4, 9));
    // predictor-checked rows around the first levels and the extremes, then bin reads
    add_row(KIND_SAMPLE, 16'd32863, 10'd0,   1'b0, '0);
    add_row(KIND_SAMPLE, 16'd32864, 10'd0,   1'b0, '0);
    add_row(KIND_SAMPLE, 16'd32608, 10'd0,   1'b0, '0);
    add_row(KIND_SAMPLE, 16'd1,     10'd0,   1'b0, '0);
    add_row(KIND_SAMPLE, 16'd32767, 10'd0,   1'b0, '0);
    add_row(KIND_BIN_READ, 16'd0,   10'd510, 1'b0, '0);
    add_row(KIND_BIN_READ, 16'd0,   10'd512, 1'b0, '0);
    add_row(KIND_BIN_READ, 16'd0,   10'd1023, 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      push_item(row.kind, row.raw, row.bin, row.typed, row.res);
    end

    // Random traffic under each pressure setting
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        kind = ($urandom_range(99) < 25) ? KIND_BIN_READ : KIND_SAMPLE;
        bin  = ($urandom_range(1) != 0) ? BIN_W'(DIFF_BIAS - 4 + $urandom_range(8))
                                        : BIN_W'($urandom);
        push_item(kind, random_sample(), bin, 1'b0, '0);
      end
    end

    // Closing full-scale swing between two reads of the zero-difference bin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_item(KIND_BIN_READ, 16'd0, 10'd511, 1'b0, '0);
    push_item(KIND_SAMPLE, 16'd65535, 10'd0, 1'b0, '0);
    push_item(KIND_SAMPLE, 16'd0, 10'd0, 1'b0, '0);
    push_item(KIND_BIN_READ, 16'd0, 10'd511, 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input transfers and %0d checked results: directed table",
             items_sent, results_seen);
    $display("and random traffic in four backpressure phases.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
